// File: sv/ppmd_pkg.sv
// Shared constants and types for the PPM frame decoder.
package ppmd_pkg;

    // Frame geometry
    localparam int MAX_CHANNELS = 8;
    localparam int DATA_W       = 32;
    localparam int IDX_W        = 3;
    localparam int CNT_W        = 4;
    localparam int CFG_IDX_W    = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_INTERVAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd3;

    // Control from the sequencer to the cell row
    typedef struct packed {
        logic             write_en;
        logic [IDX_W-1:0] write_slot;
        logic             shift;
    } row_ctrl_t;

    // Control to a single cell
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

endpackage

// File: sv/ppmd_cell.sv
// One channel slot of the frame store: loads a pulse width or takes its neighbour's value.
module ppmd_cell (
    input  logic                        clk,
    input  ppmd_pkg::cell_ctrl_t        ctrl,
    input  logic [ppmd_pkg::DATA_W-1:0] load_data,
    input  logic [ppmd_pkg::DATA_W-1:0] shift_in,
    output logic [ppmd_pkg::DATA_W-1:0] value
);

    logic [ppmd_pkg::DATA_W-1:0] value_reg;
    logic [ppmd_pkg::DATA_W-1:0] value_next;

    // Load a new pulse, or advance the neighbour's value towards the output
    always_comb
    begin
        value_next = value_reg;
        if (ctrl.load)
        begin
            value_next = load_data;
        end
        else if (ctrl.shift)
        begin
            value_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// File: sv/ppmd_ctrl.sv
// Sequencer: configuration registers, interval classification, slot count and publishing.
module ppmd_ctrl (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppmd_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ppmd_pkg::DATA_W-1:0]    interval,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ppmd_pkg::IDX_W-1:0]     channel_index,
    output logic                           last_of_frame,
    output ppmd_pkg::row_ctrl_t            row_ctrl
);

    localparam logic ST_IDLE    = 1'b0;
    localparam logic ST_PUBLISH = 1'b1;

    logic                          enable_reg;
    logic [ppmd_pkg::DATA_W-1:0]   min_reg;
    logic [ppmd_pkg::DATA_W-1:0]   sync_reg;
    logic [ppmd_pkg::CNT_W-1:0]    count_reg;

    logic                          state_reg;
    logic                          state_next;
    logic [ppmd_pkg::CNT_W-1:0]    pos_reg;
    logic [ppmd_pkg::CNT_W-1:0]    pos_next;
    logic [ppmd_pkg::IDX_W-1:0]    index_reg;
    logic [ppmd_pkg::IDX_W-1:0]    index_next;
    logic [ppmd_pkg::IDX_W-1:0]    last_idx_reg;
    logic [ppmd_pkg::IDX_W-1:0]    last_idx_next;

    logic [ppmd_pkg::CNT_W-1:0]    count_eff;
    logic                          in_take;
    logic                          out_take;
    logic                          is_pulse;
    logic                          is_sync;

    // Clamp the expected count to the store depth
    assign count_eff = (count_reg > ppmd_pkg::CNT_W'(ppmd_pkg::MAX_CHANNELS))
                     ? ppmd_pkg::CNT_W'(ppmd_pkg::MAX_CHANNELS) : count_reg;

    assign in_stall  = (state_reg == ST_PUBLISH);
    assign out_valid = (state_reg == ST_PUBLISH);
    assign in_take   = in_valid && !in_stall;
    assign out_take  = out_valid && !out_stall;

    // Classify the interval
    assign is_pulse = (interval > min_reg) && (interval < sync_reg) && (pos_reg < count_eff);
    assign is_sync  = (interval >= sync_reg);

    // Sequence slot writes and the publishing run
    always_comb
    begin
        state_next          = state_reg;
        pos_next            = pos_reg;
        index_next          = index_reg;
        last_idx_next       = last_idx_reg;
        row_ctrl.write_en   = 1'b0;
        row_ctrl.write_slot = pos_reg[ppmd_pkg::IDX_W-1:0];
        row_ctrl.shift      = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take && enable_reg)
                begin
                    if (is_pulse)
                    begin
                        row_ctrl.write_en = 1'b1;
                        pos_next          = pos_reg + 1'b1;
                    end
                    else if (is_sync)
                    begin
                        pos_next = '0;
                        if ((pos_reg == count_eff) && (count_eff != '0))
                        begin
                            state_next    = ST_PUBLISH;
                            index_next    = '0;
                            last_idx_next = ppmd_pkg::IDX_W'(count_eff - 1'b1);
                        end
                    end
                end
            end
            ST_PUBLISH:
            begin
                if (out_take)
                begin
                    row_ctrl.shift = 1'b1;
                    if (index_reg == last_idx_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        index_next = index_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign channel_index = index_reg;
    assign last_of_frame = (index_reg == last_idx_reg);

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            pos_reg      <= '0;
            index_reg    <= '0;
            last_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            index_reg    <= index_next;
            last_idx_reg <= last_idx_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            min_reg    <= '0;
            sync_reg   <= '1;
            count_reg  <= ppmd_pkg::CNT_W'(ppmd_pkg::MAX_CHANNELS);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ppmd_pkg::CFG_ENABLE:        enable_reg <= cfg_data[0];
                ppmd_pkg::CFG_MIN_INTERVAL:  min_reg    <= cfg_data;
                ppmd_pkg::CFG_SYNC_INTERVAL: sync_reg   <= cfg_data;
                ppmd_pkg::CFG_CHANNEL_COUNT: count_reg  <= cfg_data[ppmd_pkg::CNT_W-1:0];
                default:                     enable_reg <= enable_reg;
            endcase
        end
    end

endmodule

// File: sv/ppm_frame_decoder.sv
// Top level of the PPM frame decoder: sequencer and a row of channel cells.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | interval
//  out     | output    | out_valid / out_stall| channel_index, pulse_width, last_of_frame
//  cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// While idle an interval beat is taken every cycle and classified in that cycle.
// A sync gap closing a complete frame starts a run of result beats, one per expected
// channel (channel_count, clamped to eight); the cell row shifts one slot towards the
// output per taken beat, and in_stall stays high for the whole run.
// Reset clears the slot count and loads the register defaults; stored pulses
// need no reset. A stalled result holds, as the row only shifts on a taken beat.
module ppm_frame_decoder (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [ppmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ppmd_pkg::DATA_W-1:0]    cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [ppmd_pkg::DATA_W-1:0]    interval,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [ppmd_pkg::IDX_W-1:0]     channel_index,
    output logic [ppmd_pkg::DATA_W-1:0]    pulse_width,
    output logic                           last_of_frame
);

    ppmd_pkg::row_ctrl_t         row_ctrl;
    logic [ppmd_pkg::DATA_W-1:0] cell_value [ppmd_pkg::MAX_CHANNELS];

    ppmd_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .interval      (interval),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .channel_index (channel_index),
        .last_of_frame (last_of_frame),
        .row_ctrl      (row_ctrl)
    );

    // Row of cells; each hands its value to the lower neighbour on a shift
    for (genvar i = 0; i < ppmd_pkg::MAX_CHANNELS; i++)
    begin : g_cell
        ppmd_pkg::cell_ctrl_t        cctrl;
        logic [ppmd_pkg::DATA_W-1:0] shift_in;

        assign cctrl.load  = row_ctrl.write_en
                          && (row_ctrl.write_slot == ppmd_pkg::IDX_W'(i));
        assign cctrl.shift = row_ctrl.shift;

        if (i == ppmd_pkg::MAX_CHANNELS - 1)
        begin : g_tail
            assign shift_in = cell_value[i];
        end
        else
        begin : g_body
            assign shift_in = cell_value[i+1];
        end

        ppmd_cell u_cell (
            .clk       (clk),
            .ctrl      (cctrl),
            .load_data (interval),
            .shift_in  (shift_in),
            .value     (cell_value[i])
        );
    end

    // Head of the row drives the result payload
    assign pulse_width = cell_value[0];

endmodule
